@@ hdl/gvc_pkg.sv @@
// ----------------------------------------------------------------------------
// gvc_pkg
// shared widths and types of the greedy vertex coloring block
// ----------------------------------------------------------------------------
package gvc_pkg;

	localparam int ID_W    = 10;
	localparam int COLOR_W = 6;
	localparam int MAP_W   = 64;

	typedef logic [ID_W-1:0]    id_t;
	typedef logic [COLOR_W-1:0] color_t;
	typedef logic [MAP_W-1:0]   color_map_t;

	// write port of the color store
	typedef struct packed {
		logic   en;
		id_t    addr;
		color_t color;
	} mem_wr_t;

endpackage

@@ hdl/gvc_color_mem.sv @@
// ----------------------------------------------------------------------------
// gvc_color_mem
// color store: one write port, one registered read port, cleared after reset
// ----------------------------------------------------------------------------
module gvc_color_mem #(
	parameter int DEPTH = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  gvc_pkg::mem_wr_t wr,
	input  logic             rd_en,
	input  gvc_pkg::id_t     rd_addr,
	output gvc_pkg::color_t  rd_data,
	output logic             busy
);
	import gvc_pkg::*;

	localparam int AW = $clog2(DEPTH);

	color_t          mem [DEPTH];
	color_t          rd_data_q;
	logic [AW-1:0]   clr_addr_q;
	logic            busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b1;
			clr_addr_q <= '0;
		end else if (busy_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_addr_q] <= '0;
		end else if (wr.en) begin
			mem[wr.addr[AW-1:0]] <= wr.color;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr[AW-1:0]];
		end
	end

	assign rd_data = rd_data_q;
	assign busy    = busy_q;

endmodule

@@ hdl/gvc_pick.sv @@
// ----------------------------------------------------------------------------
// gvc_pick
// finds the smallest color not marked in the used-color bitmap
// ----------------------------------------------------------------------------
module gvc_pick #(
	parameter int MAX_COLORS = 64
) (
	input  gvc_pkg::color_map_t map,
	output gvc_pkg::color_t     color,
	output logic                ovf
);
	import gvc_pkg::*;

	color_map_t full_map;
	color_map_t lowest_free;
	color_t     code;

	always_comb begin
		// bit 0 and colors past the limit never count as free
		for (int i = 0; i < MAP_W; i++) begin
			full_map[i] = map[i] | (i == 0) | (i >= MAX_COLORS);
		end
		lowest_free = ~full_map & (full_map + MAP_W'(1));
		code = '0;
		for (int i = 0; i < MAP_W; i++) begin
			code = code | (lowest_free[i] ? COLOR_W'(i) : '0);
		end
	end

	assign color = code;
	assign ovf   = ~|lowest_free;

endmodule

@@ hdl/greedy_vertex_coloring.sv @@
// ----------------------------------------------------------------------------
// greedy_vertex_coloring
// greedy coloring of vertices presented in order, one edge per item
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_ready) takes one edge per item: vertex_id,
// neighbor_id, neighbor_valid and last_of_vertex. Output channel
// (out_valid / out_ready) gives one result per last item: the vertex, its
// color, the running maximum color and an overflow flag.
// Throughput is one item per cycle unless the color store is clearing or a
// last item waits on the output register; it is set by the single read port
// of the color store, which is read once per item, and the write of the
// chosen color is forwarded to an item read in the same cycle.
// A last item takes its memory read at the accepting edge, then its color
// pick goes into the output register when stage 1 advances.
// After reset the color store clears all min(MAX_VERTICES, 1024) entries
// (1024 at the default); in_ready stays low until the clear is done.
// When the receiver stalls, the result waits in the output register; non-last
// items keep flowing, and a further last item waits in stage 1 until the
// output register frees.
// ----------------------------------------------------------------------------
module greedy_vertex_coloring #(
	parameter int MAX_VERTICES = 1024,
	parameter int MAX_COLORS   = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  gvc_pkg::id_t    vertex_id,
	input  gvc_pkg::id_t    neighbor_id,
	input  logic            neighbor_valid,
	input  logic            last_of_vertex,
	output logic            out_valid,
	input  logic            out_ready,
	output gvc_pkg::id_t    colored_vertex,
	output gvc_pkg::color_t assigned_color,
	output gvc_pkg::color_t max_color,
	output logic            overflow
);
	import gvc_pkg::*;

	localparam int DEPTH = (MAX_VERTICES < (1 << ID_W)) ? MAX_VERTICES : (1 << ID_W);

	logic       busy;
	logic       in_accept;
	mem_wr_t    wr;
	color_t     rd_data;

	logic       s1_valid_q;
	id_t        vertex_s1;
	logic       last_s1;
	logic       nvalid_s1;
	logic       nrange_s1;
	logic       vrange_s1;
	logic       fwd_hit_s1;
	color_t     fwd_color_s1;

	color_map_t used_q;
	color_t     highest_q;
	logic       out_valid_q;
	id_t        colored_vertex_q;
	color_t     assigned_color_q;
	color_t     max_color_q;
	logic       overflow_q;

	logic       s1_adv;
	color_t     ngh_color;
	color_map_t mark;
	color_map_t map;
	color_t     pick_color;
	logic       pick_ovf;
	color_t     new_max;

	gvc_color_mem #(.DEPTH(DEPTH)) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.rd_en   (in_accept),
		.rd_addr (neighbor_id),
		.rd_data (rd_data),
		.busy    (busy)
	);

	gvc_pick #(.MAX_COLORS(MAX_COLORS)) u_pick (
		.map   (map),
		.color (pick_color),
		.ovf   (pick_ovf)
	);

	always_comb begin
		s1_adv    = s1_valid_q && (!last_s1 || !out_valid_q || out_ready);
		in_ready  = !busy && (!s1_valid_q || s1_adv);
		in_accept = in_valid && in_ready;
		// a color written this cycle is not yet in the read data
		ngh_color = fwd_hit_s1 ? fwd_color_s1 : rd_data;
		if (nvalid_s1 && nrange_s1) begin
			mark = color_map_t'(1) << ngh_color;
		end else if (nvalid_s1) begin
			mark = color_map_t'(1);
		end else begin
			mark = '0;
		end
		map      = used_q | mark;
		wr.en    = s1_adv && last_s1 && vrange_s1;
		wr.addr  = vertex_s1;
		wr.color = pick_color;
		new_max  = (pick_color > highest_q) ? pick_color : highest_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			used_q      <= '0;
			highest_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				used_q <= last_s1 ? '0 : map;
			end
			if (s1_adv && last_s1) begin
				highest_q   <= new_max;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			vertex_s1    <= vertex_id;
			last_s1      <= last_of_vertex;
			nvalid_s1    <= neighbor_valid;
			nrange_s1    <= 32'(neighbor_id) < MAX_VERTICES;
			vrange_s1    <= 32'(vertex_id) < MAX_VERTICES;
			fwd_hit_s1   <= wr.en && (wr.addr == neighbor_id);
			fwd_color_s1 <= wr.color;
		end
		if (s1_adv && last_s1) begin
			colored_vertex_q <= vertex_s1;
			assigned_color_q <= pick_color;
			max_color_q      <= new_max;
			overflow_q       <= pick_ovf;
		end
	end

	assign out_valid      = out_valid_q;
	assign colored_vertex = colored_vertex_q;
	assign assigned_color = assigned_color_q;
	assign max_color      = max_color_q;
	assign overflow       = overflow_q;

`ifndef SYNTHESIS
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !in_ready)
		else $error("item accepted during color store clear");

	a_ovf_color: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (overflow == (assigned_color == '0)))
		else $error("overflow flag and color disagree");

	a_max_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (max_color >= assigned_color))
		else $error("max color below assigned color");

	a_map_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && last_s1) |=> (used_q == '0))
		else $error("bitmap not cleared after last item");
`endif

endmodule

@@ sim/greedy_vertex_coloring_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_vertex_coloring_tb
// self-checking testbench of the greedy vertex coloring block
// ----------------------------------------------------------------------------
// Offers edge items through the input handshake and keeps its own copy of the
// color store, the used-color map and the highest color. Each accepted last
// item queues the coloring it should produce, and every accepted result is
// compared field by field with the oldest queued coloring. Directed cases
// come first, then random graphs under several idling patterns and a long
// output hold that backs up the input.
// ----------------------------------------------------------------------------
module greedy_vertex_coloring_tb;
	import gvc_pkg::*;

	localparam int NUM_VERTICES = 1024;
	localparam int NUM_COLORS   = 64;
	localparam int STALL_LIMIT  = 5000;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES  = 400;

	typedef struct {
		id_t    vertex;
		color_t color;
		color_t highest;
		logic   ovf;
	} coloring_t;

	logic   clk            = 1'b0;
	logic   arst_n         = 1'b0;
	logic   in_valid       = 1'b0;
	logic   in_ready;
	id_t    vertex_id      = '0;
	id_t    neighbor_id    = '0;
	logic   neighbor_valid = 1'b0;
	logic   last_of_vertex = 1'b0;
	logic   out_valid;
	logic   out_ready      = 1'b0;
	id_t    colored_vertex;
	color_t assigned_color;
	color_t max_color;
	logic   overflow;

	// predicted state of the block
	color_t     model_colors [NUM_VERTICES];
	color_map_t model_used    = '0;
	color_t     model_highest = '0;
	coloring_t  pending_colors [$];

	id_t         recent_ids [$];
	id_t         next_vertex    = '0;
	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned hold_token     = 0;
	int unsigned hold_seen      = 0;
	int unsigned hold_cnt       = 0;
	int unsigned idle_cycles    = 0;
	int unsigned errors         = 0;
	int unsigned items_in       = 0;
	int unsigned results_seen   = 0;
	int unsigned overflow_seen  = 0;

	greedy_vertex_coloring #(
		.MAX_VERTICES(NUM_VERTICES),
		.MAX_COLORS  (NUM_COLORS)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.vertex_id     (vertex_id),
		.neighbor_id   (neighbor_id),
		.neighbor_valid(neighbor_valid),
		.last_of_vertex(last_of_vertex),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.colored_vertex(colored_vertex),
		.assigned_color(assigned_color),
		.max_color     (max_color),
		.overflow      (overflow)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		foreach (model_colors[i]) model_colors[i] = '0;
	end

	task automatic report_mismatch(string what, int unsigned got, int unsigned want);
		errors++;
		$display("[%0t] mismatch: %s got %0d expected %0d", $realtime, what, got, want);
	endtask

	// mirror of one edge step: mark the neighbor color, pick on the last item
	task automatic predict_coloring(id_t v, id_t n, logic nv, logic last);
		color_t    nc;
		color_t    pick;
		coloring_t r;
		if (nv) begin
			nc = (int'(n) < NUM_VERTICES) ? model_colors[n] : '0;
			model_used[nc] = 1'b1;
		end
		if (last) begin
			pick = '0;
			for (int c = NUM_COLORS - 1; c >= 1; c--)
				if (!model_used[c]) pick = color_t'(c);
			model_used = '0;
			if (int'(v) < NUM_VERTICES) model_colors[v] = pick;
			if (pick > model_highest) model_highest = pick;
			r.vertex  = v;
			r.color   = pick;
			r.highest = model_highest;
			r.ovf     = (pick == '0);
			pending_colors = {pending_colors, r};
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			items_in++;
			predict_coloring(vertex_id, neighbor_id, neighbor_valid, last_of_vertex);
		end
	end

	always @(posedge clk) begin
		coloring_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (overflow) overflow_seen++;
			if (pending_colors.size() == 0) begin
				report_mismatch("unexpected result, vertex", 32'(colored_vertex), 0);
			end else begin
				want = pending_colors.pop_front();
				if (colored_vertex !== want.vertex)
					report_mismatch("colored_vertex", 32'(colored_vertex),
						32'(want.vertex));
				if (assigned_color !== want.color)
					report_mismatch("assigned_color", 32'(assigned_color),
						32'(want.color));
				if (max_color !== want.highest)
					report_mismatch("max_color", 32'(max_color), 32'(want.highest));
				if (overflow !== want.ovf)
					report_mismatch("overflow", 32'(overflow), 32'(want.ovf));
			end
		end
	end

	// receiver: random stalls, plus a long hold when the token changes
	always @(posedge clk) begin
		if (hold_token != hold_seen) begin
			hold_seen = hold_token;
			hold_cnt  = HOLD_CYCLES;
		end
		if (hold_cnt != 0) begin
			hold_cnt--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("[%0t] timeout: no item accepted for %0d cycles", $realtime,
					STALL_LIMIT);
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	task automatic offer_edge(id_t v, id_t n, logic nv, logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		vertex_id      <= v;
		neighbor_id    <= n;
		neighbor_valid <= nv;
		last_of_vertex <= last;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		while (pending_colors.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_idling(int unsigned send_pct, int unsigned recv_pct);
		send_idle_pct = send_pct;
		recv_stall_pct <= recv_pct;
	endtask

	// mostly ascending vertices whose neighbors were colored recently
	task automatic run_random_graph(int unsigned n_items);
		int unsigned sent;
		int unsigned degree;
		id_t         v;
		id_t         n;
		id_t         vid;
		logic        nv;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(9) == 0) begin
				v = id_t'($urandom_range(NUM_VERTICES - 1));
			end else begin
				v = next_vertex;
				next_vertex = next_vertex + 1'b1;
			end
			degree = $urandom_range(6);
			if (degree == 0) begin
				offer_edge(v, id_t'($urandom), 1'b0, 1'b1);
				sent++;
			end else begin
				for (int k = 0; k < int'(degree); k++) begin
					if (recent_ids.size() != 0 && $urandom_range(4) != 0)
						n = recent_ids[$urandom_range(recent_ids.size() - 1)];
					else
						n = id_t'($urandom);
					nv  = ($urandom_range(9) != 0);
					// stray vertex ids inside a run only matter on the last item
					vid = ($urandom_range(9) == 0 && k != int'(degree) - 1) ?
						id_t'($urandom) : v;
					offer_edge(vid, n, nv, k == int'(degree) - 1);
					sent++;
				end
			end
			recent_ids = {recent_ids, v};
			if (recent_ids.size() > 24) void'(recent_ids.pop_front());
		end
	endtask

	task automatic test_directed();
		set_idling(0, 0);
		offer_edge(10'd0, 10'd1023, 1'b0, 1'b1);       // no neighbor at all
		offer_edge(10'd1023, 10'd0, 1'b1, 1'b1);       // top vertex id
		offer_edge(10'd5, 10'd700, 1'b1, 1'b0);        // uncolored neighbor
		offer_edge(10'd5, 10'd1023, 1'b1, 1'b1);
		offer_edge(10'd6, 10'd0, 1'b1, 1'b0);
		offer_edge(10'd6, 10'd1023, 1'b1, 1'b0);
		offer_edge(10'd6, 10'd5, 1'b0, 1'b0);          // invalid neighbor marks nothing
		offer_edge(10'd6, 10'd5, 1'b1, 1'b1);
		offer_edge(10'd100, 10'd6, 1'b1, 1'b0);        // run with differing vertex ids
		offer_edge(10'd7, 10'd0, 1'b1, 1'b1);
		offer_edge(10'd0, 10'd7, 1'b1, 1'b1);          // recolor vertex 0
		offer_edge(10'd8, 10'd0, 1'b1, 1'b1);
		offer_edge(10'd8, 10'd8, 1'b1, 1'b1);          // own color
		offer_edge(10'd9, 10'd8, 1'b1, 1'b1);          // reads a color just written
		offer_edge(10'd10, 10'd9, 1'b1, 1'b0);
		offer_edge(10'd10, 10'd8, 1'b1, 1'b1);
		offer_edge(10'd11, 10'd10, 1'b1, 1'b1);
		wait_drain();
		foreach (model_colors[i])
			if (model_colors[i] != '0 && i < 16) recent_ids = {recent_ids, id_t'(i)};
		next_vertex = 10'd12;
	endtask

	task automatic test_random_free();
		set_idling(0, 0);
		run_random_graph(140);
		wait_drain();
	endtask

	task automatic test_sender_idle();
		set_idling(88, 0);
		run_random_graph(140);
		wait_drain();
	endtask

	task automatic test_receiver_stall();
		set_idling(0, 88);
		run_random_graph(140);
		wait_drain();
	endtask

	task automatic test_both_idle();
		set_idling(9, 9);
		run_random_graph(140);
		wait_drain();
	endtask

	// receiver holds off while the sender keeps offering, so the input backs up
	task automatic test_output_hold();
		set_idling(0, 0);
		hold_token <= hold_token + 1;
		run_random_graph(80);
		wait_drain();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random_free();
		test_sender_idle();
		test_receiver_stall();
		test_both_idle();
		test_output_hold();
		$display("run covered %0d edge items and %0d colorings, %0d of them overflowed",
			items_in, results_seen, overflow_seen);
		$display("phases: directed, free flow, sender gaps, receiver stalls, mixed, " ,
			"long output hold; %0d mismatches", errors);
		if (errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
